// ----- src/ale_pkg.sv -----
// ----------------------------------------------------------------------------
// Array list engine package
// Field widths, request actions and result status codes shared by the
// list engine and its entry memory.
// ----------------------------------------------------------------------------
package ale_pkg;

   localparam int WORD_W      = 32;
   localparam int ACT_W       = 3;
   localparam int POS_W       = 7;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 7;
   localparam int REQ_DATA_W  = 40;
   localparam int REQ_USER_W  = ACT_W;
   localparam int RSP_DATA_W  = 40;
   localparam int RSP_USER_W  = STATUS_W;

   typedef enum logic [ACT_W-1:0] {
      ACT_APPEND  = 3'd0,
      ACT_HEAD    = 3'd1,
      ACT_INSERT  = 3'd2,
      ACT_READ    = 3'd3,
      ACT_DELETE  = 3'd4,
      ACT_CLEAR   = 3'd5,
      ACT_REVERSE = 3'd6
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

endpackage

// ----- src/ale_ram.sv -----
// ----------------------------------------------------------------------------
// Array list entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ale_ram #(
   parameter int DEPTH = 64
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [ale_pkg::WORD_W-1:0]   wr_data,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [ale_pkg::WORD_W-1:0]   rd_data
);
   import ale_pkg::*;

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/array_list_engine.sv -----
// ----------------------------------------------------------------------------
// Array list engine
// A bounded list of signed words with insert, delete, read, clear and reverse.
// ----------------------------------------------------------------------------
// Every request transaction yields one response transaction. The block takes
// one request at a time and is not ready while it works. All entry moves go
// through the entry memory one entry at a time, each read and then written:
// an insert at position p shifts the entries from p to the end up by one, a
// delete at position p shifts the entries after p down by one, and a reverse
// swaps entries pairwise from both ends inward. Clear, rejected requests and
// the unused action code move no entry. A finished response waits in an
// output register, so the next request is taken while it is still pending.
module array_list_engine #(
   parameter int DEPTH = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // value [31:0], position [38:32], zero [39]
   input  logic [ale_pkg::REQ_DATA_W-1:0]  req_tdata,
   // action [2:0]
   input  logic [ale_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // read_value [31:0], count [38:32], zero [39]
   output logic [ale_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // status [1:0]
   output logic [ale_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import ale_pkg::*;

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int IW   = AW + 1;
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_WR,
      S_DEL_RD,
      S_DEL_WR,
      S_REV_A,
      S_REV_B,
      S_REV_C,
      S_REV_D,
      S_READ_A,
      S_READ_B,
      S_DONE
   } state_type;

   state_type           state_ff;
   logic [CW-1:0]       count_ff;
   logic [AW-1:0]       idx_ff;
   logic [AW-1:0]       hi_ff;
   logic [AW-1:0]       pos_ff;
   logic [WORD_W-1:0]   word_ff;
   logic [WORD_W-1:0]   temp_ff;
   status_type          status_ff;
   logic [WORD_W-1:0]   value_ff;
   logic                rsp_valid_ff;
   status_type          rsp_status_ff;
   logic [WORD_W-1:0]   rsp_value_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [WORD_W-1:0]   wr_data;
   logic [AW-1:0]       rd_addr;
   logic [WORD_W-1:0]   rd_data;

   logic [WORD_W-1:0]   req_value;
   logic [POS_W-1:0]    req_pos;
   logic [CMPW-1:0]     pos_ext;
   logic [CMPW-1:0]     cnt_ext;
   logic                list_full;
   logic                list_empty;
   logic                req_accept;
   logic                rsp_free;

   assign req_value  = req_tdata[WORD_W-1:0];
   assign req_pos    = req_tdata[WORD_W+POS_W-1:WORD_W];
   assign pos_ext    = CMPW'(req_pos);
   assign cnt_ext    = CMPW'(count_ff);
   assign list_full  = (count_ff == CW'(DEPTH));
   assign list_empty = (count_ff == '0);
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   ale_ram #(
      .DEPTH(DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = rd_data;
      rd_addr = idx_ff;
      unique case (state_ff)
         S_INS_RD: begin
            if (idx_ff > pos_ff) begin
               rd_addr = idx_ff - AW'(1);
            end else begin
               wr_en   = 1'b1;
               wr_addr = pos_ff;
               wr_data = word_ff;
            end
         end
         S_INS_WR: begin
            wr_en = 1'b1;
         end
         S_DEL_RD: begin
            rd_addr = idx_ff + AW'(1);
         end
         S_DEL_WR: begin
            wr_en = 1'b1;
         end
         S_REV_B: begin
            rd_addr = hi_ff;
         end
         S_REV_C: begin
            wr_en = 1'b1;
         end
         S_REV_D: begin
            wr_en   = 1'b1;
            wr_addr = hi_ff;
            wr_data = temp_ff;
         end
         S_READ_A: begin
            rd_addr = pos_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  value_ff <= '0;
                  word_ff  <= req_value;
                  case (action_type'(req_tuser))
                     ACT_APPEND, ACT_HEAD, ACT_INSERT: begin
                        if (list_full) begin
                           status_ff <= ST_FULL;
                           state_ff  <= S_DONE;
                        end else if (action_type'(req_tuser) == ACT_INSERT &&
                                     pos_ext > cnt_ext) begin
                           status_ff <= ST_RANGE;
                           state_ff  <= S_DONE;
                        end else begin
                           status_ff <= ST_OK;
                           idx_ff    <= AW'(count_ff);
                           state_ff  <= S_INS_RD;
                           case (action_type'(req_tuser))
                              ACT_APPEND: pos_ff <= AW'(count_ff);
                              ACT_HEAD:   pos_ff <= '0;
                              default:    pos_ff <= AW'(req_pos);
                           endcase
                        end
                     end
                     ACT_READ, ACT_DELETE: begin
                        if (list_empty) begin
                           status_ff <= ST_EMPTY;
                           state_ff  <= S_DONE;
                        end else if (pos_ext >= cnt_ext) begin
                           status_ff <= ST_RANGE;
                           state_ff  <= S_DONE;
                        end else begin
                           status_ff <= ST_OK;
                           pos_ff    <= AW'(req_pos);
                           idx_ff    <= AW'(req_pos);
                           state_ff  <= (action_type'(req_tuser) == ACT_READ) ?
                                        S_READ_A : S_DEL_RD;
                        end
                     end
                     ACT_CLEAR: begin
                        state_ff <= S_DONE;
                        if (list_empty) begin
                           status_ff <= ST_EMPTY;
                        end else begin
                           status_ff <= ST_OK;
                           count_ff  <= '0;
                        end
                     end
                     ACT_REVERSE: begin
                        if (list_empty) begin
                           status_ff <= ST_EMPTY;
                           state_ff  <= S_DONE;
                        end else begin
                           status_ff <= ST_OK;
                           idx_ff    <= '0;
                           hi_ff     <= AW'(count_ff - CW'(1));
                           state_ff  <= S_REV_A;
                        end
                     end
                     default: begin
                        status_ff <= ST_OK;
                        state_ff  <= S_DONE;
                     end
                  endcase
               end
            end
            S_INS_RD: begin
               if (idx_ff > pos_ff) begin
                  state_ff <= S_INS_WR;
               end else begin
                  count_ff <= count_ff + CW'(1);
                  state_ff <= S_DONE;
               end
            end
            S_INS_WR: begin
               idx_ff   <= idx_ff - AW'(1);
               state_ff <= S_INS_RD;
            end
            S_DEL_RD: begin
               if ((IW'(idx_ff) + IW'(1)) < IW'(count_ff)) begin
                  state_ff <= S_DEL_WR;
               end else begin
                  count_ff <= count_ff - CW'(1);
                  state_ff <= S_DONE;
               end
            end
            S_DEL_WR: begin
               idx_ff   <= idx_ff + AW'(1);
               state_ff <= S_DEL_RD;
            end
            S_REV_A: begin
               state_ff <= (idx_ff < hi_ff) ? S_REV_B : S_DONE;
            end
            S_REV_B: begin
               temp_ff  <= rd_data;
               state_ff <= S_REV_C;
            end
            S_REV_C: begin
               state_ff <= S_REV_D;
            end
            S_REV_D: begin
               idx_ff   <= idx_ff + AW'(1);
               hi_ff    <= hi_ff - AW'(1);
               state_ff <= S_REV_A;
            end
            S_READ_A: begin
               state_ff <= S_READ_B;
            end
            S_READ_B: begin
               value_ff <= rd_data;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_value_ff  <= value_ff;
                  rsp_count_ff  <= COUNT_W'(count_ff);
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - WORD_W - COUNT_W){1'b0}}, rsp_count_ff, rsp_value_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("Entry count exceeds the list depth.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("Engine still ready after taking a request transaction.");

   a_swap_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REV_D) |-> (idx_ff < hi_ff))
      else $error("Reverse swap with crossed pointers.");

endmodule
